### hdl/pvsc_pkg.sv
// Shared types, codes and arithmetic helpers for the peak/valley step counter.
`timescale 1ns / 1ps

package pvsc_pkg;

    // Field widths
    localparam int unsigned ModeW  = 2;
    localparam int unsigned AccelW = 12;
    localparam int unsigned SumW   = 14;
    localparam int unsigned CountW = 16;
    localparam int unsigned StyleW = 2;
    localparam int unsigned ThrW   = 14;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 14;
    localparam int unsigned DirW   = 2;

    // Item modes
    localparam logic [ModeW-1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [ModeW-1:0] MODE_CLEAR   = 2'd1;
    localparam logic [ModeW-1:0] MODE_RESTART = 2'd2;

    // Direction tracker codes
    localparam logic [DirW-1:0] DIR_UNDET = 2'd0;
    localparam logic [DirW-1:0] DIR_RISE  = 2'd1;
    localparam logic [DirW-1:0] DIR_FALL  = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_STYLE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_WALK  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_RUN   = 2'd2;

    // Style code that selects the walk threshold; all others select run
    localparam logic [StyleW-1:0] STYLE_WALK = 2'd0;

    // Reset values of the thresholds
    localparam logic [ThrW-1:0] WALK_THR_RST = 14'd200;
    localparam logic [ThrW-1:0] RUN_THR_RST  = 14'd150;

    // Reciprocal of ten, scaled by 2^19; exact floor for any 16-bit dividend
    localparam logic [15:0] RECIP10 = 16'd52429;

    // One input beat as held in the input register
    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic [AccelW-1:0] accel_x;
        logic [AccelW-1:0] accel_y;
        logic [AccelW-1:0] accel_z;
    } pvsc_item_t;

    // Control passed from the top level to the filter and tracker
    typedef struct packed {
        logic             adv;
        logic [ModeW-1:0] mode;
    } pvsc_ctrl_t;

    // floor(x / 10) for a dividend up to 40950, result fits 12 bits
    function automatic logic [AccelW-1:0] div10(input logic [15:0] x);
        logic [31:0] prod;
        prod = x * RECIP10;
        return prod[30:19];
    endfunction

endpackage

### hdl/pvsc_filter.sv
// Three-axis first-order smoothing filter and axis sum.
`timescale 1ns / 1ps

module pvsc_filter
    import pvsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pvsc_ctrl_t          ctrl,
    input  pvsc_item_t          item,
    output logic [SumW-1:0]     sum_next
);

    logic [AccelW-1:0] smooth_reg  [3];
    logic [AccelW-1:0] smooth_next [3];
    logic [AccelW-1:0] raw         [3];
    logic [AccelW-1:0] sample_val  [3];

    // New filter value per axis: (raw + 9*old) / 10
    always_comb
    begin
        raw[0] = item.accel_x;
        raw[1] = item.accel_y;
        raw[2] = item.accel_z;
        for (int i = 0; i < 3; i++)
        begin
            sample_val[i] = div10({4'd0, raw[i]}
                                  + {1'b0, smooth_reg[i], 3'd0}
                                  + {4'd0, smooth_reg[i]});
        end
    end

    // Select next filter state by mode
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (ctrl.mode)
                MODE_SAMPLE:  smooth_next[i] = sample_val[i];
                MODE_RESTART: smooth_next[i] = '0;
                default:      smooth_next[i] = smooth_reg[i];
            endcase
        end
    end

    // Sum of the three smoothed axes after this beat
    assign sum_next = {2'd0, smooth_next[0]} + {2'd0, smooth_next[1]}
                    + {2'd0, smooth_next[2]};

    // Filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                smooth_reg[i] <= '0;
            end
        end
        else if (ctrl.adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                smooth_reg[i] <= smooth_next[i];
            end
        end
    end

    // Restart leaves all three axes at zero
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.adv && (ctrl.mode == MODE_RESTART) |=>
        (smooth_reg[0] == '0) && (smooth_reg[1] == '0) && (smooth_reg[2] == '0))
        else $error("filter not cleared after restart");

endmodule

### hdl/pvsc_tracker.sv
// Peak/valley direction tracker and step count.
`timescale 1ns / 1ps

module pvsc_tracker
    import pvsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pvsc_ctrl_t          ctrl,
    input  logic [SumW-1:0]     sum,
    input  logic [ThrW-1:0]     limit,
    output logic [CountW-1:0]   steps_next,
    output logic                hit
);

    logic [SumW-1:0]   prev_reg,   prev_next;
    logic [SumW-1:0]   valley_reg, valley_next;
    logic [SumW-1:0]   peak_reg,   peak_next;
    logic [DirW-1:0]   dir_reg,    dir_next;
    logic [CountW-1:0] steps_reg;
    logic [SumW:0]     swing;
    logic              swing_ok;

    // Swing against the previous sum, which becomes the valley on a turn
    assign swing    = {1'b0, peak_reg} - {1'b0, prev_reg};
    assign swing_ok = !swing[SumW] && (swing[SumW-1:0] > limit);

    // Tracker next state
    always_comb
    begin
        prev_next   = prev_reg;
        valley_next = valley_reg;
        peak_next   = peak_reg;
        dir_next    = dir_reg;
        steps_next  = steps_reg;
        hit         = 1'b0;
        unique case (ctrl.mode)
            MODE_SAMPLE:
            begin
                prev_next = sum;
                if (prev_reg == '0)
                begin
                    // seed both levels
                    valley_next = sum;
                    peak_next   = sum;
                end
                else if (dir_reg == DIR_UNDET)
                begin
                    if (sum > prev_reg)
                    begin
                        dir_next    = DIR_RISE;
                        valley_next = prev_reg;
                    end
                    else
                    begin
                        dir_next  = DIR_FALL;
                        peak_next = prev_reg;
                    end
                end
                else if (dir_reg == DIR_RISE)
                begin
                    if (sum < prev_reg)
                    begin
                        peak_next = prev_reg;
                        dir_next  = DIR_FALL;
                    end
                end
                else if (dir_reg == DIR_FALL)
                begin
                    // valley-to-rise turn: candidate step
                    if (sum > prev_reg)
                    begin
                        valley_next = prev_reg;
                        dir_next    = DIR_RISE;
                        if (swing_ok)
                        begin
                            steps_next = steps_reg + 1'b1;
                            hit        = 1'b1;
                        end
                    end
                end
            end
            MODE_CLEAR:
            begin
                steps_next = '0;
            end
            MODE_RESTART:
            begin
                prev_next = '0;
                dir_next  = DIR_UNDET;
            end
            default:
            begin
                steps_next = steps_reg;
            end
        endcase
    end

    // Tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            valley_reg <= '0;
            peak_reg   <= '0;
            dir_reg    <= DIR_UNDET;
            steps_reg  <= '0;
        end
        else if (ctrl.adv)
        begin
            prev_reg   <= prev_next;
            valley_reg <= valley_next;
            peak_reg   <= peak_next;
            dir_reg    <= dir_next;
            steps_reg  <= steps_next;
        end
    end

    // A step only on a falling-to-rising turn of a sample
    a_hit_on_turn: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (ctrl.mode == MODE_SAMPLE) && (dir_reg == DIR_FALL) && (sum > prev_reg))
        else $error("step counted outside a valley turn");

    // A counted step advances the count by exactly one
    a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.adv && hit |=> steps_reg == $past(steps_reg) + 16'd1)
        else $error("step count did not advance by one");

endmodule

### hdl/peak_valley_step_counter_top.sv
// Top level of the peak/valley step counter: handshake, config and result registers.
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_stall     mode, accel_x, accel_y, accel_z
//  out       output     out_valid / out_stall   step_count, step_detected, filtered_sum
//  cfg       input      cfg_we                  cfg_index, cfg_data
//
//  One beat per cycle unless out stalls; each beat passes the input and result registers.
//  The filter divide-by-ten multiply and the swing compare set the single-cycle path.
//  Reset clears filters, tracker, count, valid flags and loads threshold defaults.
//  A stall on out backs up through the result and input registers to in_stall.
`timescale 1ns / 1ps

module peak_valley_step_counter_top
    import pvsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ModeW-1:0]    mode,
    input  logic [AccelW-1:0]   accel_x,
    input  logic [AccelW-1:0]   accel_y,
    input  logic [AccelW-1:0]   accel_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CountW-1:0]   step_count,
    output logic                step_detected,
    output logic [SumW-1:0]     filtered_sum,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    logic [StyleW-1:0] style_reg;
    logic [ThrW-1:0]   walk_reg;
    logic [ThrW-1:0]   run_reg;
    logic [ThrW-1:0]   limit;

    pvsc_item_t        item_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [CountW-1:0] step_count_reg;
    logic              step_detected_reg;
    logic [SumW-1:0]   filtered_sum_reg;

    logic              in_accept;
    logic              out_free;
    logic              advance;
    pvsc_ctrl_t        ctrl;
    logic [SumW-1:0]   sum_next;
    logic [CountW-1:0] steps_next;
    logic              hit;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg <= STYLE_WALK;
            walk_reg  <= WALK_THR_RST;
            run_reg   <= RUN_THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STYLE: style_reg <= cfg_data[StyleW-1:0];
                REG_WALK:  walk_reg  <= cfg_data[ThrW-1:0];
                REG_RUN:   run_reg   <= cfg_data[ThrW-1:0];
                default:   style_reg <= style_reg;
            endcase
        end
    end

    assign limit = (style_reg != STYLE_WALK) ? run_reg : walk_reg;

    // Flow control: input register feeds result register
    assign out_free       = !out_valid_reg || !out_stall;
    assign advance        = in_valid_reg && out_free;
    assign in_stall       = in_valid_reg && !out_free;
    assign in_accept      = in_valid && !in_stall;
    assign in_valid_next  = in_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input beat register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.mode    <= mode;
            item_reg.accel_x <= accel_x;
            item_reg.accel_y <= accel_y;
            item_reg.accel_z <= accel_z;
        end
    end

    assign ctrl.adv  = advance;
    assign ctrl.mode = item_reg.mode;

    pvsc_filter u_filter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .item     (item_reg),
        .sum_next (sum_next)
    );

    pvsc_tracker u_tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sum        (sum_next),
        .limit      (limit),
        .steps_next (steps_next),
        .hit        (hit)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            step_count_reg    <= steps_next;
            step_detected_reg <= hit;
            filtered_sum_reg  <= sum_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign step_count    = step_count_reg;
    assign step_detected = step_detected_reg;
    assign filtered_sum  = filtered_sum_reg;

    // A held input beat is never dropped while the result side is blocked
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("input beat lost while blocked");

    // A new result appears only after the input register moved into it
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result valid without an advancing beat");

endmodule
